>>> src/serial_command_frame_parser_defines.svh
// Assertion macros used by the frame parser RTL.
`ifndef SERIAL_COMMAND_FRAME_PARSER_DEFINES_SVH
`define SERIAL_COMMAND_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SCFP_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scfp check failed");

// Next-cycle implication, checked outside reset.
`define SCFP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scfp check failed");

`endif

>>> src/scfp_pkg.sv
`default_nettype none

package scfp_pkg;

    localparam logic [7:0] CH_END   = 8'h23;
    localparam logic [7:0] CH_OPEN  = 8'h3C;
    localparam logic [7:0] CH_CLOSE = 8'h3E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_Y     = 8'h79;
    localparam logic [7:0] CH_Z     = 8'h7A;

    // Bit positions in the letters-seen mask
    localparam int LTR_A = 0;
    localparam int LTR_B = 1;
    localparam int LTR_X = 2;
    localparam int LTR_Y = 3;
    localparam int LTR_Z = 4;

    localparam logic [1:0] LEN_MAX = 2'd2;

    typedef enum logic [1:0] {
        PH_SKIP = 2'd0,
        PH_NUM  = 2'd1,
        PH_DONE = 2'd2
    } scfp_phase_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_OVR_ON  = 3'd1,
        ACT_OVR_OFF = 3'd2,
        ACT_SET_X   = 3'd3,
        ACT_SET_Y   = 3'd4,
        ACT_SET_Z   = 3'd5
    } scfp_action_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } scfp_item_t;

endpackage

`default_nettype wire

>>> src/scfp_in_stage.sv
`default_nettype none

module scfp_in_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // [7:0] rx_byte
    input  wire logic              s_tuser,   // [0] mode
    input  wire logic              pop,
    output logic                   item_valid,
    output scfp_pkg::scfp_item_t   item
);

    logic                 valid_reg;
    logic                 valid_next;
    scfp_pkg::scfp_item_t item_reg;
    logic                 load;

    assign s_tready   = !valid_reg || pop;
    assign load       = s_tvalid && s_tready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.mode    <= s_tuser;
            item_reg.rx_byte <= s_tdata;
        end
    end

endmodule

`default_nettype wire

>>> src/scfp_parse.sv
`default_nettype none
`include "serial_command_frame_parser_defines.svh"

module scfp_parse #(
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     item_valid,
    input  wire scfp_pkg::scfp_item_t     item,
    output logic                          pop,
    input  wire logic                     m_tready,
    output logic                          m_tvalid,
    output logic [2:0]                    action,
    output logic                          override_on,
    output logic [VALUE_WIDTH-1:0]        axis_x,
    output logic [VALUE_WIDTH-1:0]        axis_y,
    output logic [VALUE_WIDTH-1:0]        axis_z
);

    // Frame state
    logic [1:0]             len_reg, len_next;
    logic [4:0]             letters_reg, letters_next;
    logic                   open_reg, open_next;
    logic                   close_reg, close_next;
    logic                   pv_reg, pv_next;
    logic                   inner_reg, inner_next;
    scfp_pkg::scfp_phase_t  phase_reg, phase_next;
    logic                   neg_reg, neg_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;

    // Persistent state and result
    logic                   ovr_reg, ovr_next;
    logic [VALUE_WIDTH-1:0] ax_reg, ax_next;
    logic [VALUE_WIDTH-1:0] ay_reg, ay_next;
    logic [VALUE_WIDTH-1:0] az_reg, az_next;
    scfp_pkg::scfp_action_t action_reg, action_next;
    logic                   valid_reg, valid_next;

    logic [7:0]             ch;
    logic                   is_end;
    logic                   is_digit;
    logic                   is_space;
    logic                   out_free;
    logic                   step;
    logic                   take_char;
    logic                   end_step;
    logic                   feed;
    logic [VALUE_WIDTH-1:0] acc_digit;
    logic [VALUE_WIDTH-1:0] value;

    always_comb
    begin
        ch = item.rx_byte;
        if (ch >= 8'h41 && ch <= 8'h5A)
        begin
            ch = ch + 8'h20;
        end
    end

    assign is_end    = item.mode || (item.rx_byte == scfp_pkg::CH_END);
    assign is_digit  = (ch >= 8'h30) && (ch <= 8'h39);
    assign is_space  = (ch == 8'h20) || ((ch >= 8'h09) && (ch <= 8'h0D));
    assign out_free  = !valid_reg || m_tready;
    // Hold a frame end until the result register can take it
    assign step      = item_valid && (!is_end || out_free);
    assign pop       = step;
    assign take_char = step && !is_end;
    assign end_step  = step && is_end;
    assign feed      = take_char && open_reg && !close_reg && (ch != scfp_pkg::CH_CLOSE);

    assign acc_digit = (acc_reg << 3) + (acc_reg << 1)
                     + {{(VALUE_WIDTH-4){1'b0}}, ch[3:0]};
    assign value     = neg_reg ? (VALUE_WIDTH'(0) - acc_reg) : acc_reg;

    // Frame flags
    always_comb
    begin
        len_next     = len_reg;
        letters_next = letters_reg;
        open_next    = open_reg;
        close_next   = close_reg;
        pv_next      = pv_reg;
        inner_next   = inner_reg;
        if (end_step)
        begin
            len_next     = 2'd0;
            letters_next = 5'd0;
            open_next    = 1'b0;
            close_next   = 1'b0;
            pv_next      = 1'b0;
            inner_next   = 1'b0;
        end
        else if (take_char)
        begin
            if (len_reg != scfp_pkg::LEN_MAX)
            begin
                len_next = len_reg + 2'd1;
            end
            case (ch)
                scfp_pkg::CH_A: letters_next[scfp_pkg::LTR_A] = 1'b1;
                scfp_pkg::CH_B: letters_next[scfp_pkg::LTR_B] = 1'b1;
                scfp_pkg::CH_X: letters_next[scfp_pkg::LTR_X] = 1'b1;
                scfp_pkg::CH_Y: letters_next[scfp_pkg::LTR_Y] = 1'b1;
                scfp_pkg::CH_Z: letters_next[scfp_pkg::LTR_Z] = 1'b1;
                default: ;
            endcase
            if (ch == scfp_pkg::CH_CLOSE)
            begin
                if (!close_reg)
                begin
                    close_next = 1'b1;
                    pv_next    = open_reg && inner_reg;
                end
            end
            else if (open_reg && !close_reg)
            begin
                inner_next = 1'b1;
            end
            else if (ch == scfp_pkg::CH_OPEN)
            begin
                open_next = 1'b1;
            end
        end
    end

    // Number scanner: next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (end_step)
        begin
            phase_next = scfp_pkg::PH_SKIP;
        end
        else if (feed)
        begin
            case (phase_reg)
                scfp_pkg::PH_SKIP:
                begin
                    if (!is_space)
                    begin
                        if (ch == scfp_pkg::CH_PLUS || ch == scfp_pkg::CH_MINUS || is_digit)
                        begin
                            phase_next = scfp_pkg::PH_NUM;
                        end
                        else
                        begin
                            phase_next = scfp_pkg::PH_DONE;
                        end
                    end
                end
                scfp_pkg::PH_NUM:
                begin
                    if (!is_digit)
                    begin
                        phase_next = scfp_pkg::PH_DONE;
                    end
                end
                default: ;
            endcase
        end
    end

    // Number scanner: sign and accumulator
    always_comb
    begin
        neg_next = neg_reg;
        acc_next = acc_reg;
        if (end_step)
        begin
            neg_next = 1'b0;
            acc_next = '0;
        end
        else if (feed)
        begin
            case (phase_reg)
                scfp_pkg::PH_SKIP:
                begin
                    if (ch == scfp_pkg::CH_PLUS || ch == scfp_pkg::CH_MINUS)
                    begin
                        neg_next = (ch == scfp_pkg::CH_MINUS);
                    end
                    else if (is_digit)
                    begin
                        acc_next = acc_digit;
                    end
                end
                scfp_pkg::PH_NUM:
                begin
                    if (is_digit)
                    begin
                        acc_next = acc_digit;
                    end
                end
                default: ;
            endcase
        end
    end

    // Command decode at frame end
    always_comb
    begin
        ovr_next    = ovr_reg;
        ax_next     = ax_reg;
        ay_next     = ay_reg;
        az_next     = az_reg;
        action_next = action_reg;
        valid_next  = valid_reg;
        if (end_step)
        begin
            valid_next  = 1'b1;
            action_next = scfp_pkg::ACT_NONE;
            if (len_reg == scfp_pkg::LEN_MAX)
            begin
                if (letters_reg[scfp_pkg::LTR_A])
                begin
                    ovr_next    = 1'b1;
                    action_next = scfp_pkg::ACT_OVR_ON;
                end
                else if (letters_reg[scfp_pkg::LTR_B])
                begin
                    ovr_next    = 1'b0;
                    action_next = scfp_pkg::ACT_OVR_OFF;
                end
                else if (pv_reg)
                begin
                    if (letters_reg[scfp_pkg::LTR_X])
                    begin
                        ax_next     = value;
                        action_next = scfp_pkg::ACT_SET_X;
                    end
                    else if (letters_reg[scfp_pkg::LTR_Y])
                    begin
                        ay_next     = value;
                        action_next = scfp_pkg::ACT_SET_Y;
                    end
                    else if (letters_reg[scfp_pkg::LTR_Z])
                    begin
                        az_next     = value;
                        action_next = scfp_pkg::ACT_SET_Z;
                    end
                end
            end
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= 2'd0;
            letters_reg <= 5'd0;
            open_reg    <= 1'b0;
            close_reg   <= 1'b0;
            pv_reg      <= 1'b0;
            inner_reg   <= 1'b0;
            phase_reg   <= scfp_pkg::PH_SKIP;
            neg_reg     <= 1'b0;
            acc_reg     <= '0;
            ovr_reg     <= 1'b0;
            ax_reg      <= '0;
            ay_reg      <= '0;
            az_reg      <= '0;
            action_reg  <= scfp_pkg::ACT_NONE;
            valid_reg   <= 1'b0;
        end
        else
        begin
            len_reg     <= len_next;
            letters_reg <= letters_next;
            open_reg    <= open_next;
            close_reg   <= close_next;
            pv_reg      <= pv_next;
            inner_reg   <= inner_next;
            phase_reg   <= phase_next;
            neg_reg     <= neg_next;
            acc_reg     <= acc_next;
            ovr_reg     <= ovr_next;
            ax_reg      <= ax_next;
            ay_reg      <= ay_next;
            az_reg      <= az_next;
            action_reg  <= action_next;
            valid_reg   <= valid_next;
        end
    end

    // Stored state changes only at a frame end, which waits for a free result slot,
    // so it can be shown directly next to the registered action.
    assign m_tvalid    = valid_reg;
    assign action      = action_reg;
    assign override_on = ovr_reg;
    assign axis_x      = ax_reg;
    assign axis_y      = ay_reg;
    assign axis_z      = az_reg;

    `SCFP_ASSERT_NOW(a_ovr_on_flag, clk, rst_n, valid_reg && action_reg == scfp_pkg::ACT_OVR_ON, ovr_reg)
    `SCFP_ASSERT_NOW(a_ovr_off_flag, clk, rst_n, valid_reg && action_reg == scfp_pkg::ACT_OVR_OFF, !ovr_reg)
    `SCFP_ASSERT_NOW(a_param_needs_delims, clk, rst_n, pv_reg, open_reg && close_reg && inner_reg)
    `SCFP_ASSERT_NEXT(a_frame_cleared, clk, rst_n, end_step, len_reg == 2'd0 && !open_reg && valid_reg)

endmodule

`default_nettype wire

>>> src/serial_command_frame_parser.sv
// Serial command frame parser.
// Input channel s_*: one item per received character (s_tuser = 0, s_tdata = byte)
// or an idle-gap marker (s_tuser = 1, s_tdata ignored). A '#' byte or an idle gap
// closes the current frame; every other byte is collected into it.
// Output channel m_*: one item per closed frame carrying the decoded action,
// the override flag and the three stored axis positions after that frame.
// A frame-closing item passes through two register stages: the input register,
// then the result register.
// Throughput: one input item per cycle while no frame-closing item waits for the
// result slot, set by the update of the frame state between the two registers.
// When the receiver holds m_tready low, the result stays on m_tdata; ordinary
// characters keep flowing in, and the next frame-closing item waits in the
// input register until the result slot frees, which then back-pressures s_*.
// Reset clears the override flag, all axis positions and the frame in progress;
// no output item is pending after reset.
`default_nettype none

module serial_command_frame_parser #(
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [7:0] rx_byte
    input  wire logic                 s_tuser,   // [0] mode
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // action, override_on, axis_x, axis_y, axis_z from bit 0 up, zero padded
    output logic [((4 + 3*VALUE_WIDTH + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int OUT_W  = ((4 + 3*VALUE_WIDTH + 7) / 8) * 8;
    localparam int X_LSB  = 4;
    localparam int Y_LSB  = X_LSB + VALUE_WIDTH;
    localparam int Z_LSB  = Y_LSB + VALUE_WIDTH;

    logic                   item_valid;
    scfp_pkg::scfp_item_t   item;
    logic                   pop;
    logic [2:0]             action;
    logic                   override_on;
    logic [VALUE_WIDTH-1:0] axis_x;
    logic [VALUE_WIDTH-1:0] axis_y;
    logic [VALUE_WIDTH-1:0] axis_z;

    scfp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .pop        (pop),
        .item_valid (item_valid),
        .item       (item)
    );

    scfp_parse #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item        (item),
        .pop         (pop),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .action      (action),
        .override_on (override_on),
        .axis_x      (axis_x),
        .axis_y      (axis_y),
        .axis_z      (axis_z)
    );

    always_comb
    begin
        m_tdata                            = {OUT_W{1'b0}};
        m_tdata[2:0]                       = action;
        m_tdata[3]                         = override_on;
        m_tdata[X_LSB +: VALUE_WIDTH]      = axis_x;
        m_tdata[Y_LSB +: VALUE_WIDTH]      = axis_y;
        m_tdata[Z_LSB +: VALUE_WIDTH]      = axis_z;
    end

endmodule

`default_nettype wire

>>> tb/tb_serial_command_frame_parser.sv
module tb_serial_command_frame_parser;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_W      = 16;
    localparam int RES_W        = ((4 + 3 * VALUE_W + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 1400;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    typedef logic [7:0] char_q_t[$];

    typedef struct {
        scfp_pkg::scfp_action_t action;
        logic                   override_on;
        logic [VALUE_W-1:0]     axis_x;
        logic [VALUE_W-1:0]     axis_y;
        logic [VALUE_W-1:0]     axis_z;
    } frame_result_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic [7:0]       s_tdata = 8'h00;
    logic             s_tuser = 1'b0;
    logic             m_tready = 1'b0;
    logic             s_tready;
    logic             m_tvalid;
    logic [RES_W-1:0] m_tdata;

    // Predicted parser state
    logic                  ovr_state;
    logic [VALUE_W-1:0]    axis_pos [3];
    logic [1:0]            frame_len;
    logic [4:0]            letter_mask;
    logic                  open_flag;
    logic                  close_flag;
    logic                  param_ok;
    logic                  inner_any;
    scfp_pkg::scfp_phase_t num_phase;
    logic                  num_neg;
    logic [VALUE_W-1:0]    num_acc;

    frame_result_t expected_results[$];
    int            fail_count = 0;
    int            items_sent = 0;
    int            cycle_count = 0;
    bit            no_idle = 1'b0;
    bit            hold_req = 1'b0;

    serial_command_frame_parser #(
        .VALUE_WIDTH(VALUE_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_frame_state();
        frame_len   = '0;
        letter_mask = '0;
        open_flag   = 1'b0;
        close_flag  = 1'b0;
        param_ok    = 1'b0;
        inner_any   = 1'b0;
        num_phase   = scfp_pkg::PH_SKIP;
        num_neg     = 1'b0;
        num_acc     = '0;
    endfunction

    function automatic void feed_param_char(logic [7:0] c);
        logic digit;
        digit = (c >= CH_ZERO && c <= CH_NINE);
        if (num_phase == scfp_pkg::PH_SKIP)
        begin
            if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
                return;
            if (c == scfp_pkg::CH_PLUS || c == scfp_pkg::CH_MINUS)
            begin
                num_neg   = (c == scfp_pkg::CH_MINUS);
                num_phase = scfp_pkg::PH_NUM;
                return;
            end
            num_phase = digit ? scfp_pkg::PH_NUM : scfp_pkg::PH_DONE;
        end
        else if (num_phase == scfp_pkg::PH_NUM)
        begin
            if (!digit)
                num_phase = scfp_pkg::PH_DONE;
        end
        else
            return;
        // wrap modulo 2^VALUE_W
        if (digit && num_phase == scfp_pkg::PH_NUM)
            num_acc = VALUE_W'(num_acc * 10 + (c - CH_ZERO));
    endfunction

    function automatic void take_frame_char(logic [7:0] raw);
        logic [7:0] c;
        c = (raw >= CH_UPPER_A && raw <= CH_UPPER_Z) ? (raw | CASE_BIT) : raw;
        if (frame_len < scfp_pkg::LEN_MAX)
            frame_len++;
        case (c)
            scfp_pkg::CH_A: letter_mask[scfp_pkg::LTR_A] = 1'b1;
            scfp_pkg::CH_B: letter_mask[scfp_pkg::LTR_B] = 1'b1;
            scfp_pkg::CH_X: letter_mask[scfp_pkg::LTR_X] = 1'b1;
            scfp_pkg::CH_Y: letter_mask[scfp_pkg::LTR_Y] = 1'b1;
            scfp_pkg::CH_Z: letter_mask[scfp_pkg::LTR_Z] = 1'b1;
            default: ;
        endcase
        // only the first '>' closes the parameter
        if (c == scfp_pkg::CH_CLOSE)
        begin
            if (!close_flag)
            begin
                close_flag = 1'b1;
                param_ok   = open_flag && inner_any;
            end
            return;
        end
        if (open_flag && !close_flag)
        begin
            inner_any = 1'b1;
            feed_param_char(c);
            return;
        end
        if (c == scfp_pkg::CH_OPEN)
            open_flag = 1'b1;
    endfunction

    function automatic void close_frame();
        frame_result_t      r;
        logic [VALUE_W-1:0] value;
        value    = num_neg ? -num_acc : num_acc;
        r.action = scfp_pkg::ACT_NONE;
        if (frame_len >= scfp_pkg::LEN_MAX)
        begin
            if (letter_mask[scfp_pkg::LTR_A])
            begin
                ovr_state = 1'b1;
                r.action  = scfp_pkg::ACT_OVR_ON;
            end
            else if (letter_mask[scfp_pkg::LTR_B])
            begin
                ovr_state = 1'b0;
                r.action  = scfp_pkg::ACT_OVR_OFF;
            end
            else if (param_ok)
            begin
                if (letter_mask[scfp_pkg::LTR_X])
                begin
                    axis_pos[0] = value;
                    r.action    = scfp_pkg::ACT_SET_X;
                end
                else if (letter_mask[scfp_pkg::LTR_Y])
                begin
                    axis_pos[1] = value;
                    r.action    = scfp_pkg::ACT_SET_Y;
                end
                else if (letter_mask[scfp_pkg::LTR_Z])
                begin
                    axis_pos[2] = value;
                    r.action    = scfp_pkg::ACT_SET_Z;
                end
            end
        end
        r.override_on = ovr_state;
        r.axis_x      = axis_pos[0];
        r.axis_y      = axis_pos[1];
        r.axis_z      = axis_pos[2];
        expected_results.push_back(r);
        clear_frame_state();
    endfunction

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic char_q_t text(string s);
        char_q_t q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(8'(s[i]));
        return q;
    endfunction

    // Called at a rising edge; returns at the edge that accepted the item.
    task automatic send_item(input logic md, input logic [7:0] b);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= md;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        if (!md && b != scfp_pkg::CH_END)
            take_frame_char(b);
        else
            close_frame();
        items_sent++;
    endtask

    task automatic send_frame(input char_q_t chars, input logic by_gap);
        foreach (chars[i])
            send_item(1'b0, chars[i]);
        if (by_gap)
            send_item(1'b1, 8'($urandom_range(0, 255)));
        else
            send_item(1'b0, scfp_pkg::CH_END);
    endtask

    task automatic test_short_frames();
        send_item(1'b1, 8'hFF);
        send_frame(text("a"), 1'b0);
        send_frame(text("A"), 1'b1);
        send_frame('{8'h00, 8'hFF}, 1'b0);
    endtask

    task automatic test_override_commands();
        send_frame(text("Ab"), 1'b1);
        send_frame(text("bB"), 1'b0);
        send_frame(text("xa"), 1'b0);
    endtask

    task automatic test_axis_parameters();
        send_frame(text("x<>"), 1'b0);
        send_frame(text("z><5>"), 1'b0);
        send_frame(text("Y< -70000>"), 1'b0);
        send_frame(text("X<\t+65535q>"), 1'b1);
        send_frame(text("x<32768>"), 1'b0);
        send_frame(text("zy<+>"), 1'b0);
        send_frame(text("Z<  7"), 1'b0);
    endtask

    // Hold the receiver off while frames keep coming so the input stalls.
    task automatic test_output_backpressure();
        no_idle  = 1'b1;
        hold_req = 1'b1;
        repeat (40) send_frame(text("y<-12>"), 1'b0);
        no_idle  = 1'b0;
    endtask

    task automatic test_random_frames();
        char_q_t    chars;
        logic [7:0] c;
        int         start;
        int         pick;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            chars.delete();
            if ($urandom_range(0, 29) == 0)
                no_idle = !no_idle;
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(0, 6)) chars.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                repeat ($urandom_range(0, 2)) chars.push_back(8'($urandom_range(32, 126)));
                repeat ($urandom_range(1, 2))
                begin
                    pick = $urandom_range(0, 9);
                    case (pick)
                        0:       c = scfp_pkg::CH_A;
                        1:       c = scfp_pkg::CH_B;
                        default: c = (pick % 3 == 0) ? scfp_pkg::CH_X :
                                     (pick % 3 == 1) ? scfp_pkg::CH_Y : scfp_pkg::CH_Z;
                    endcase
                    if ($urandom_range(0, 1))
                        c = c & ~CASE_BIT;
                    chars.push_back(c);
                end
                if ($urandom_range(0, 9) < 8)
                begin
                    if ($urandom_range(0, 9) == 0)
                        chars.push_back(scfp_pkg::CH_CLOSE);
                    chars.push_back(scfp_pkg::CH_OPEN);
                    repeat ($urandom_range(0, 2))
                        chars.push_back($urandom_range(0, 5) == 0 ?
                                        CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR)));
                    pick = $urandom_range(0, 3);
                    if (pick == 0)
                        chars.push_back(scfp_pkg::CH_PLUS);
                    else if (pick == 1)
                        chars.push_back(scfp_pkg::CH_MINUS);
                    repeat ($urandom_range(0, 6))
                        chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                    if ($urandom_range(0, 4) == 0)
                        chars.push_back(8'($urandom_range(0, 255)));
                    if ($urandom_range(0, 9) != 0)
                        chars.push_back(scfp_pkg::CH_CLOSE);
                end
                repeat ($urandom_range(0, 1)) chars.push_back(8'($urandom_range(32, 126)));
            end
            send_frame(chars, $urandom_range(0, 3) == 0);
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall = draw_wait();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin : result_check
        frame_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with no frame pending, got %h", $time, m_tdata);
                fail_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (m_tdata[2:0] !== exp_r.action)
                begin
                    $display("%0t: action expected %0d got %0d",
                             $time, exp_r.action, m_tdata[2:0]);
                    fail_count++;
                end
                if (m_tdata[3] !== exp_r.override_on)
                begin
                    $display("%0t: override_on expected %0d got %0d",
                             $time, exp_r.override_on, m_tdata[3]);
                    fail_count++;
                end
                if (m_tdata[19:4] !== exp_r.axis_x)
                begin
                    $display("%0t: axis_x expected %0d got %0d",
                             $time, $signed(exp_r.axis_x), $signed(m_tdata[19:4]));
                    fail_count++;
                end
                if (m_tdata[35:20] !== exp_r.axis_y)
                begin
                    $display("%0t: axis_y expected %0d got %0d",
                             $time, $signed(exp_r.axis_y), $signed(m_tdata[35:20]));
                    fail_count++;
                end
                if (m_tdata[51:36] !== exp_r.axis_z)
                begin
                    $display("%0t: axis_z expected %0d got %0d",
                             $time, $signed(exp_r.axis_z), $signed(m_tdata[51:36]));
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("serial_command_frame_parser test failed");
            $finish;
        end
    end

    initial
    begin
        ovr_state = 1'b0;
        axis_pos  = '{default: '0};
        clear_frame_state();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_frames();
        test_override_commands();
        test_axis_parameters();
        test_output_backpressure();
        test_random_frames();

        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("serial_command_frame_parser test passed");
        else
            $display("serial_command_frame_parser test failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/scfp_pkg.sv
src/scfp_in_stage.sv
src/scfp_parse.sv
src/serial_command_frame_parser.sv
tb/tb_serial_command_frame_parser.sv
